### hdl/tsp_subset_dp_solver_unit_macros.svh
// Assertion macros for the tour solver unit.
`ifndef TSP_SUBSET_DP_SOLVER_UNIT_MACROS_SVH
`define TSP_SUBSET_DP_SOLVER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TSP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsp solver assertion failed");
// next-cycle implication
`define TSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsp solver assertion failed");
`else
`define TSP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TSP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/tsp_pkg.sv
// Shared constants, types and helpers of the tour solver unit.
package tsp_pkg;

   localparam int CITIES_DEF = 8;
   localparam int DIST_W     = 16;
   localparam int OUT_W      = 19;
   localparam int CNT_W      = 4;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic [CNT_W-1:0] CNT_RESET = 4'd8;
   localparam logic [OUT_W-1:0] OUT_MAX   = 19'h7FFFF;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_SOLVE = 1'b1;

   typedef struct packed {
      logic             start;
      logic             take;
      logic [CNT_W-1:0] n;
   } seq_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seq_stat_type;

   // bits needed for a path or tour cost over the given number of cities
   function automatic int cost_width(input int cities);
      cost_width = $clog2(cities * ((1 << DIST_W) - 1) + 1);
   endfunction

endpackage

### hdl/tsp_subset_dp_solver_unit.sv
// Top level of the subset DP tour solver: request decode, CSR, RAMs and result register.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tuser func, tdata row/col/distance
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata tour_length
//  csr     | in        | csr_valid/csr_ready   | csr_data cities_used
//
// A solve over n cities makes one cost-table read per candidate predecessor,
// plus a select and a write-back step for each subset and end city.
// No clearing pass after reset: both RAMs are valid only once written.
// A finished result waits in the rsp register; the solver holds until it drains.
`include "tsp_subset_dp_solver_unit_macros.svh"
module tsp_subset_dp_solver_unit
   import tsp_pkg::*;
#(
   parameter int CITIES = CITIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // row[2:0], col[5:3], distance[21:6]
   input  logic                  req_tuser,  // func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // tour_length[18:0]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CNT_W-1:0]      csr_data
);

   localparam int DistAw = $clog2(CITIES * CITIES);
   localparam int CostAw = $clog2((1 << (CITIES - 1)) * CITIES);
   localparam int CostW  = cost_width(CITIES);

   logic [CNT_W-1:0]  cities_ff, cities_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [OUT_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [2:0]        row, col;
   logic [DIST_W-1:0] distance;
   logic              req_accept, take;
   logic              dist_wr_en;
   logic [DistAw-1:0] dist_wr_addr, dist_rd_addr;
   logic [DIST_W-1:0] dist_rd_data;
   logic [CostAw-1:0] cost_rd_addr, cost_wr_addr;
   logic [CostW-1:0]  cost_rd_data, cost_wr_data;
   logic              cost_wr_en;
   logic [OUT_W-1:0]  seq_result;
   seq_cmd_type       cmd;
   seq_stat_type      stat;

   assign row      = req_tdata[2:0];
   assign col      = req_tdata[5:3];
   assign distance = req_tdata[21:6];

   assign req_tready = !stat.busy;
   assign req_accept = req_tvalid && req_tready;

   // out-of-range rows and columns are dropped
   assign dist_wr_en   = req_accept && (req_tuser == FUNC_WRITE) &&
                         (32'(row) < CITIES) && (32'(col) < CITIES);
   assign dist_wr_addr = DistAw'(32'(row) * CITIES + 32'(col));

   assign take      = stat.done && (!rsp_tvalid_ff || rsp_tready);
   assign cmd.start = req_accept && (req_tuser == FUNC_SOLVE);
   assign cmd.take  = take;
   assign cmd.n     = cities_ff;

   tsp_ram #(
      .DEPTH(CITIES * CITIES),
      .WIDTH(DIST_W)
   ) u_dist_ram (
      .clock  (clock),
      .wr_en  (dist_wr_en),
      .wr_addr(dist_wr_addr),
      .wr_data(distance),
      .rd_addr(dist_rd_addr),
      .rd_data(dist_rd_data)
   );

   tsp_ram #(
      .DEPTH((1 << (CITIES - 1)) * CITIES),
      .WIDTH(CostW)
   ) u_cost_ram (
      .clock  (clock),
      .wr_en  (cost_wr_en),
      .wr_addr(cost_wr_addr),
      .wr_data(cost_wr_data),
      .rd_addr(cost_rd_addr),
      .rd_data(cost_rd_data)
   );

   tsp_seq #(
      .CITIES(CITIES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .result      (seq_result),
      .dist_rd_addr(dist_rd_addr),
      .dist_rd_data(dist_rd_data),
      .cost_rd_addr(cost_rd_addr),
      .cost_rd_data(cost_rd_data),
      .cost_wr_en  (cost_wr_en),
      .cost_wr_addr(cost_wr_addr),
      .cost_wr_data(cost_wr_data)
   );

   always_comb begin
      cities_in     = csr_valid ? csr_data : cities_ff;
      rsp_tvalid_in = take ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);
      rsp_data_in   = take ? seq_result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cities_ff     <= CNT_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         cities_ff     <= cities_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - OUT_W){1'b0}}, rsp_data_ff};

   // finished result stays put until the rsp register takes it
   `TSP_ASSERT_NEXT(a_result_held, clock, reset, stat.done && !take, stat.done && $stable(seq_result))
   // a solve request always starts the sequencer
   `TSP_ASSERT_NEXT(a_solve_starts, clock, reset, cmd.start, stat.busy)
   // write-back never hits the entry being read
   `TSP_ASSERT_IMPL(a_no_cost_collision, clock, reset, cost_wr_en, cost_wr_addr != cost_rd_addr)
   // a response appears only after a hand-off from the sequencer
   `TSP_ASSERT_IMPL(a_rsp_from_take, clock, reset, $rose(rsp_tvalid_ff), $past(take))

endmodule

### hdl/tsp_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module tsp_ram
   import tsp_pkg::*;
#(
   parameter int DEPTH = CITIES_DEF * CITIES_DEF,
   parameter int WIDTH = DIST_W,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

### hdl/tsp_seq.sv
// Subset DP sequencer: walks subsets, end cities and predecessors over the two RAMs.
module tsp_seq
   import tsp_pkg::*;
#(
   parameter int CITIES = CITIES_DEF,
   localparam int SubW   = CITIES - 1,
   localparam int SubW1  = CITIES,
   localparam int CityW  = $clog2(CITIES),
   localparam int DistAw = $clog2(CITIES * CITIES),
   localparam int CostAw = $clog2((1 << (CITIES - 1)) * CITIES),
   localparam int CostW  = cost_width(CITIES)
) (
   input  logic              clock,
   input  logic              reset,
   input  seq_cmd_type       cmd,
   output seq_stat_type      stat,
   output logic [OUT_W-1:0]  result,
   output logic [DistAw-1:0] dist_rd_addr,
   input  logic [DIST_W-1:0] dist_rd_data,
   output logic [CostAw-1:0] cost_rd_addr,
   input  logic [CostW-1:0]  cost_rd_data,
   output logic              cost_wr_en,
   output logic [CostAw-1:0] cost_wr_addr,
   output logic [CostW-1:0]  cost_wr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SEL   = 3'd1;
   localparam logic [2:0] ST_ISSUE = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [SubW-1:0]  s_ff, s_in;
   logic [SubW-1:0]  full_ff, full_in;
   logic [SubW-1:0]  rest_ff, rest_in;
   logic [CityW-1:0] j_ff, j_in;
   logic [CityW-1:0] k_ff, k_in;
   logic [CityW-1:0] tgt_ff, tgt_in;
   logic [CityW-1:0] last_ff, last_in;
   logic             fin_ff, fin_in;
   logic             base_ff, base_in;
   logic             pv_ff, pv_in;
   logic             pbase_ff, pbase_in;
   logic [CostW-1:0] best_ff, best_in;
   logic             have_ff, have_in;
   logic [OUT_W-1:0] result_ff, result_in;

   logic [SubW-1:0]  j_bit, k_bit, rest_sel;
   logic             has_j, k_in_rest;
   logic [CostW-1:0] cand, best_nx;
   logic             have_nx;
   logic [CNT_W-1:0] n_clamp;
   logic [31:0]      best_wide;
   logic [SubW-1:0]  s_adv;
   logic [CityW-1:0] j_adv;
   logic             fin_adv;

   always_comb begin
      j_bit     = SubW'(1) << (j_ff - 1'b1);
      k_bit     = SubW'(1) << (k_ff - 1'b1);
      has_j     = |(s_ff & j_bit);
      rest_sel  = s_ff & ~j_bit;
      k_in_rest = |(rest_ff & k_bit);

      // compare stage: data of the read issued in the previous cycle
      cand    = pbase_ff ? CostW'(dist_rd_data) : cost_rd_data + CostW'(dist_rd_data);
      best_nx = best_ff;
      have_nx = have_ff;
      if (pv_ff && (!have_ff || cand < best_ff)) begin
         best_nx = cand;
         have_nx = 1'b1;
      end
      best_wide = 32'(best_nx);

      if (cmd.n < CNT_W'(2)) begin
         n_clamp = CNT_W'(2);
      end else if (32'(cmd.n) > CITIES) begin
         n_clamp = CNT_W'(CITIES);
      end else begin
         n_clamp = cmd.n;
      end

      // next end city, next subset, or the closing pass
      s_adv   = s_ff;
      j_adv   = j_ff + 1'b1;
      fin_adv = fin_ff;
      if (j_ff == last_ff) begin
         j_adv = CityW'(1);
         if (s_ff == full_ff) begin
            fin_adv = 1'b1;
         end else begin
            s_adv = s_ff + 1'b1;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      s_in      = s_ff;
      full_in   = full_ff;
      rest_in   = rest_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      tgt_in    = tgt_ff;
      last_in   = last_ff;
      fin_in    = fin_ff;
      base_in   = base_ff;
      pv_in     = 1'b0;
      pbase_in  = base_ff;
      best_in   = best_nx;
      have_in   = have_nx;
      result_in = result_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               last_in  = CityW'(n_clamp - 1'b1);
               full_in  = SubW'((SubW1'(1) << (n_clamp - 1'b1)) - 1'b1);
               s_in     = SubW'(1);
               j_in     = CityW'(1);
               fin_in   = 1'b0;
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            have_in = 1'b0;
            if (fin_ff) begin
               // closing pass: full set back to the start city
               rest_in  = full_ff;
               tgt_in   = '0;
               base_in  = 1'b0;
               k_in     = CityW'(1);
               state_in = ST_ISSUE;
            end else if (!has_j) begin
               s_in   = s_adv;
               j_in   = j_adv;
               fin_in = fin_adv;
            end else begin
               rest_in = rest_sel;
               tgt_in  = j_ff;
               if (rest_sel == '0) begin
                  base_in = 1'b1;
                  k_in    = '0;
               end else begin
                  base_in = 1'b0;
                  k_in    = CityW'(1);
               end
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            pv_in    = base_ff | k_in_rest;
            pbase_in = base_ff;
            if (base_ff || k_ff == last_ff) begin
               state_in = ST_WAIT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            if (fin_ff) begin
               result_in = (best_wide > 32'(OUT_MAX)) ? OUT_MAX : best_wide[OUT_W-1:0];
               state_in  = ST_DONE;
            end else begin
               s_in     = s_adv;
               j_in     = j_adv;
               fin_in   = fin_adv;
               state_in = ST_SEL;
            end
         end
         ST_DONE: begin
            if (cmd.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff      <= s_in;
      full_ff   <= full_in;
      rest_ff   <= rest_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      tgt_ff    <= tgt_in;
      last_ff   <= last_in;
      fin_ff    <= fin_in;
      base_ff   <= base_in;
      pbase_ff  <= pbase_in;
      best_ff   <= best_in;
      have_ff   <= have_in;
      result_ff <= result_in;
   end

   assign dist_rd_addr = DistAw'(32'(k_ff) * CITIES + 32'(tgt_ff));
   assign cost_rd_addr = CostAw'(32'(rest_ff) * CITIES + 32'(k_ff));
   assign cost_wr_en   = (state_ff == ST_WAIT) && !fin_ff;
   assign cost_wr_addr = CostAw'(32'(s_ff) * CITIES + 32'(tgt_ff));
   assign cost_wr_data = best_nx;

   assign stat.busy = state_ff != ST_IDLE;
   assign stat.done = state_ff == ST_DONE;
   assign result    = result_ff;

endmodule
